>>> src/mva_pkg.sv
// Shared types, constants and the semitone table of the voice allocator.
// Used by every module of the block; depends on nothing.
package mva_pkg;

  localparam int VOICE_COUNT   = 6;
  localparam int MIDI_CHANNELS = 16;
  localparam int VOICE_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int MAX_RESULTS   = 12;
  localparam int WCNT_W        = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_BEND     = 2'd2;

  localparam logic [7:0]  FREE_MARK    = 8'h80;
  localparam logic [13:0] BEND_CENTER  = 14'h2000;
  localparam logic [3:0]  REG_VOL_BASE = 4'd8;
  // Reciprocal of 55 scaled by 2^27, rounded up; exact for dividends below 2^21.
  localparam logic [21:0] DIV55_RECIP  = 22'd2440323;

  typedef enum logic [1:0] {
    OP_ON,
    OP_OFF,
    OP_BEND
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  ch;
    logic [6:0]  note;
    logic [3:0]  vol;
    logic [13:0] bend;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [6:0]  note;
    logic [13:0] bend;
  } per_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] period;
  } per_rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_VOL,
    B_PSTART,
    B_PWAIT,
    B_LO,
    B_HI,
    B_SCAN
  } back_state_e;

  typedef enum logic [3:0] {
    P_IDLE,
    P_T,
    P_T2,
    P_T3,
    P_FINE,
    P_M,
    P_TOT,
    P_DIV,
    P_DONE
  } per_state_e;

  function automatic logic [17:0] semi_lut(logic [3:0] s);
    logic [17:0] r;
    case (s)
      4'd0:    r = 18'd131072;
      4'd1:    r = 18'd138866;
      4'd2:    r = 18'd147123;
      4'd3:    r = 18'd155872;
      4'd4:    r = 18'd165140;
      4'd5:    r = 18'd174960;
      4'd6:    r = 18'd185364;
      4'd7:    r = 18'd196386;
      4'd8:    r = 18'd208064;
      4'd9:    r = 18'd220436;
      4'd10:   r = 18'd233544;
      4'd11:   r = 18'd247431;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

  // Voice indexes stay below sixteen, so (v * 11) >> 5 equals v / 3.
  function automatic logic [3:0] div3(logic [3:0] v);
    logic [8:0] p;
    p = 9'(v) * 9'd11;
    return p[8:5];
  endfunction

endpackage

>>> src/mva_in_if.sv
// Input event channel of the voice allocator.
// Depends on nothing.
interface mva_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  midi_channel;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [13:0] bend_value;

  modport source(output valid, action, midi_channel, note, velocity, bend_value, input ready);
  modport sink(input valid, action, midi_channel, note, velocity, bend_value, output ready);
endinterface

>>> src/mva_out_if.sv
// Register write channel of the voice allocator.
// Depends on nothing.
interface mva_out_if;
  logic       valid;
  logic       ready;
  logic       chip_select;
  logic [3:0] reg_address;
  logic [7:0] reg_data;
  logic       last;

  modport source(output valid, chip_select, reg_address, reg_data, last, input ready);
  modport sink(input valid, chip_select, reg_address, reg_data, last, output ready);
endinterface

>>> src/mva_cfg_if.sv
// Configuration write channel of the voice allocator.
// Depends on nothing.
interface mva_cfg_if;
  logic valid;
  logic ready;
  logic alloc_mode;

  modport source(output valid, alloc_mode, input ready);
  modport sink(input valid, alloc_mode, output ready);
endinterface

>>> src/mva_front.sv
// Front end: accepts events, classifies them and holds them in a two-entry queue.
// Depends on mva_pkg and mva_in_if.
module mva_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  mva_in_if.sink       in_i,
  output logic         cmd_valid_o,
  output mva_pkg::cmd_t cmd_o,
  input  logic         cmd_pop_i
);

  mva_pkg::cmd_t fifo_q [2];
  mva_pkg::cmd_t fifo_d [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, push, pop;
  mva_pkg::cmd_t cls;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign accept      = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cls.ch   = in_i.midi_channel;
    cls.note = in_i.note;
    cls.vol  = in_i.velocity[6:3];
    cls.bend = in_i.bend_value;
    cls.op   = mva_pkg::OP_BEND;
    push     = accept;
    case (in_i.action)
      mva_pkg::ACT_NOTE_ON: begin
        cls.op = (in_i.velocity == 7'd0) ? mva_pkg::OP_OFF : mva_pkg::OP_ON;
      end
      mva_pkg::ACT_NOTE_OFF: cls.op = mva_pkg::OP_OFF;
      mva_pkg::ACT_BEND:     cls.op = mva_pkg::OP_BEND;
      default:               push = 1'b0;
    endcase
  end

  always_comb begin
    fifo_d = fifo_q;
    wr_d   = wr_q;
    rd_d   = rd_q;
    cnt_d  = cnt_q;
    if (push) begin
      fifo_d[wr_q] = cls;
      wr_d         = ~wr_q;
    end
    if (pop) begin
      rd_d = ~rd_q;
    end
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fifo_q <= fifo_d;
  end

endmodule

>>> src/mva_period.sv
// Tone period unit: fixed-point exponential through a chain of registered
// multiplies and a reciprocal multiply for the divide by 440. Depends on mva_pkg.
module mva_period (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mva_pkg::per_req_t req_i,
  output mva_pkg::per_rsp_t rsp_o
);

  mva_pkg::per_state_e state_q, state_d;
  logic [3:0]  e_q, e_d, s_q, s_d;
  logic [11:0] f_q, f_d;
  logic [25:0] t_q, t_d;
  logic [21:0] t2_q, t2_d;
  logic [17:0] t3_q, t3_d;
  logic [30:0] fine_q, fine_d;
  logic [31:0] m_q, m_d;
  logic [23:0] div_q, div_d;
  logic [15:0] quo_q, quo_d;

  logic [19:0] q_w;
  logic [15:0] eprod_w;
  logic [3:0]  e_w;
  logic [7:0]  s_w;
  logic [51:0] p52;
  logic [47:0] p48;
  logic [33:0] p34;
  logic [48:0] pm, ptot, shifted;
  logic [42:0] pdiv;

  always_comb begin
    q_w = 20'd577536 - {1'b0, req_i.note, 12'd0} - {{6{req_i.bend[13]}}, req_i.bend};
    eprod_w = 16'(q_w[19:12]) * 16'd171;
    e_w = eprod_w[14:11];
    s_w = q_w[19:12] - 8'(e_w) * 8'd12;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mva_pkg::P_IDLE: if (req_i.start) state_d = mva_pkg::P_T;
      mva_pkg::P_T:    state_d = mva_pkg::P_T2;
      mva_pkg::P_T2:   state_d = mva_pkg::P_T3;
      mva_pkg::P_T3:   state_d = mva_pkg::P_FINE;
      mva_pkg::P_FINE: state_d = mva_pkg::P_M;
      mva_pkg::P_M:    state_d = mva_pkg::P_TOT;
      mva_pkg::P_TOT:  state_d = mva_pkg::P_DIV;
      mva_pkg::P_DIV:  state_d = mva_pkg::P_DONE;
      mva_pkg::P_DONE: state_d = mva_pkg::P_IDLE;
      default:         state_d = mva_pkg::P_IDLE;
    endcase
  end

  always_comb begin
    e_d = e_q; s_d = s_q; f_d = f_q;
    t_d = t_q; t2_d = t2_q; t3_d = t3_q;
    fine_d = fine_q; m_d = m_q;
    div_d = div_q; quo_d = quo_q;
    p52 = 52'(t_q) * 52'(t_q);
    p48 = 48'(t2_q) * 48'(t_q);
    p34 = 34'(t3_q[17:1]) * 34'd43691;
    pm = 49'(mva_pkg::semi_lut(s_q)) * 49'(fine_q);
    ptot = 49'(m_q) * 49'd111861;
    shifted = ptot >> (6'd36 - 6'(e_q));
    // Dividing by 440 is a shift by three and a multiply by the reciprocal of 55.
    pdiv = 43'(div_q[23:3]) * 43'(mva_pkg::DIV55_RECIP);
    rsp_o.done = 1'b0;
    rsp_o.period = quo_q;
    unique case (state_q)
      mva_pkg::P_IDLE: begin
        if (req_i.start) begin
          e_d = e_w;
          s_d = s_w[3:0];
          f_d = q_w[11:0];
        end
      end
      mva_pkg::P_T:    t_d = 26'(f_q) * 26'd15142;
      mva_pkg::P_T2:   t2_d = p52[51:30];
      mva_pkg::P_T3:   t3_d = p48[47:30];
      mva_pkg::P_FINE: begin
        fine_d = 31'h4000_0000 + 31'(t_q) + 31'(t2_q[21:1]) + 31'(p34[33:17]);
      end
      mva_pkg::P_M:    m_d = pm[48:17];
      mva_pkg::P_TOT:  div_d = shifted[23:0];
      mva_pkg::P_DIV:  quo_d = pdiv[42:27];
      mva_pkg::P_DONE: rsp_o.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mva_pkg::P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d; s_q <= s_d; f_q <= f_d;
    t_q <= t_d; t2_q <= t2_d; t3_q <= t3_d;
    fine_q <= fine_d; m_q <= m_d;
    div_q <= div_d; quo_q <= quo_d;
  end

endmodule

>>> src/mva_back.sv
// Back end: voice state, allocation and stealing, and the register write sequencer.
// Depends on mva_pkg, mva_cfg_if and mva_out_if.
module mva_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  mva_cfg_if.sink           cfg_i,
  mva_out_if.source         out_o,
  input  logic              cmd_valid_i,
  input  mva_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  output mva_pkg::per_req_t per_req_o,
  input  mva_pkg::per_rsp_t per_rsp_i
);

  localparam int VC = mva_pkg::VOICE_COUNT;
  localparam int VW = mva_pkg::VOICE_W;
  localparam int WW = mva_pkg::WCNT_W;

  mva_pkg::back_state_e state_q, state_d;
  logic        mode_q;
  logic [7:0]  vnote_q [VC];
  logic [7:0]  vnote_d [VC];
  logic [3:0]  vch_q [VC];
  logic [3:0]  vch_d [VC];
  logic [7:0]  vorder_q [VC];
  logic [7:0]  vorder_d [VC];
  logic [13:0] cbend_q [mva_pkg::MIDI_CHANNELS];
  logic [13:0] cbend_d [mva_pkg::MIDI_CHANNELS];
  logic [7:0]  pc_q, pc_d;
  logic [VW-1:0] voice_q, voice_d;
  logic [6:0]  note_q, note_d;
  logic [13:0] bend_q, bend_d;
  logic [3:0]  vol_q, vol_d;
  logic        is_on_q, is_on_d, is_bend_q, is_bend_d, final_q, final_d;
  logic [VC-1:0] mask_q, mask_d;
  logic [WW-1:0] wcnt_q, wcnt_d;
  logic [15:0] per_q, per_d;
  logic        ov_q, ov_d;
  logic        cs_q, cs_d, last_q, last_d;
  logic [3:0]  addr_q, addr_d;
  logic [7:0]  data_q, data_d;

  logic          emit_ok, room, at_last, ring, ch_ok;
  logic          free_hit, steal_hit, off_hit, on_hit, off_any;
  logic [VW-1:0] free_idx, steal_idx, off_idx, on_idx, off_sel, scan_idx;
  logic [VC-1:0] bmask, mask_rest;
  logic [7:0]    best, age;
  logic [3:0]    vdiv, vmod;
  logic [13:0]   new_bend;

  assign cfg_i.ready = 1'b1;
  assign out_o.valid = ov_q;
  assign out_o.chip_select = cs_q;
  assign out_o.reg_address = addr_q;
  assign out_o.reg_data = data_q;
  assign out_o.last = last_q;
  assign emit_ok = !ov_q || out_o.ready;
  assign room = (wcnt_q < WW'(mva_pkg::MAX_RESULTS));
  assign at_last = (wcnt_q == WW'(mva_pkg::MAX_RESULTS - 1));
  assign ring = !mode_q;
  assign ch_ok = (int'(cmd_i.ch) < VC);
  assign vdiv = mva_pkg::div3(4'(voice_q));
  assign vmod = 4'(voice_q) - 4'(vdiv * 4'd3);
  assign new_bend = cmd_i.bend - mva_pkg::BEND_CENTER;

  always_comb begin
    free_hit = 1'b0; free_idx = '0;
    off_hit = 1'b0; off_idx = '0;
    steal_hit = 1'b0; steal_idx = '0; best = 8'hFF;
    scan_idx = '0;
    age = 8'd0;
    for (int i = VC - 1; i >= 0; i--) begin
      if (vnote_q[i][7]) begin
        free_hit = 1'b1;
        free_idx = VW'(i);
      end
      if (vnote_q[i] == {1'b0, cmd_i.note}) begin
        off_hit = 1'b1;
        off_idx = VW'(i);
      end
      if (mask_q[i]) scan_idx = VW'(i);
    end
    for (int i = 0; i < VC; i++) begin
      age = vorder_q[i] - pc_q - 8'd1;
      if (vorder_q[i] != pc_q && (!steal_hit || age < best)) begin
        steal_hit = 1'b1;
        steal_idx = VW'(i);
        best = age;
      end
      bmask[i] = (vch_q[i] == cmd_i.ch) && !vnote_q[i][7];
    end
    mask_rest = mask_q & ~(VC'(1) << scan_idx);
    on_hit  = ring ? (free_hit || steal_hit) : ch_ok;
    on_idx  = ring ? (free_hit ? free_idx : steal_idx) : VW'(cmd_i.ch);
    off_any = ring ? off_hit : ch_ok;
    off_sel = ring ? off_idx : VW'(cmd_i.ch);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mva_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            mva_pkg::OP_ON:  if (on_hit) state_d = mva_pkg::B_VOL;
            mva_pkg::OP_OFF: if (off_any) state_d = mva_pkg::B_VOL;
            default:         state_d = mva_pkg::B_SCAN;
          endcase
        end
      end
      mva_pkg::B_VOL: begin
        if (emit_ok) state_d = is_on_q ? mva_pkg::B_PSTART : mva_pkg::B_IDLE;
      end
      mva_pkg::B_PSTART: state_d = mva_pkg::B_PWAIT;
      mva_pkg::B_PWAIT:  if (per_rsp_i.done) state_d = mva_pkg::B_LO;
      mva_pkg::B_LO:     if (emit_ok) state_d = mva_pkg::B_HI;
      mva_pkg::B_HI: begin
        if (emit_ok) state_d = is_bend_q ? mva_pkg::B_SCAN : mva_pkg::B_IDLE;
      end
      mva_pkg::B_SCAN: begin
        state_d = (mask_q == '0) ? mva_pkg::B_IDLE : mva_pkg::B_PSTART;
      end
      default: state_d = mva_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    vnote_d = vnote_q; vch_d = vch_q; vorder_d = vorder_q; cbend_d = cbend_q;
    pc_d = pc_q; voice_d = voice_q; note_d = note_q; bend_d = bend_q;
    vol_d = vol_q; is_on_d = is_on_q; is_bend_d = is_bend_q; final_d = final_q;
    mask_d = mask_q; wcnt_d = wcnt_q; per_d = per_q;
    cs_d = cs_q; addr_d = addr_q; data_d = data_q; last_d = last_q;
    ov_d = ov_q && !out_o.ready;
    cmd_pop_o = 1'b0;
    per_req_o.start = 1'b0;
    per_req_o.note = note_q;
    per_req_o.bend = bend_q;
    unique case (state_q)
      mva_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          wcnt_d = '0;
          case (cmd_i.op)
            mva_pkg::OP_ON: begin
              is_on_d = 1'b1; is_bend_d = 1'b0; final_d = 1'b1;
              if (on_hit) begin
                voice_d = on_idx;
                note_d = cmd_i.note;
                bend_d = cbend_q[cmd_i.ch];
                vol_d = cmd_i.vol;
                vnote_d[on_idx] = {1'b0, cmd_i.note};
                vch_d[on_idx] = cmd_i.ch;
                vorder_d[on_idx] = pc_q;
                pc_d = pc_q + 8'd1;
              end
            end
            mva_pkg::OP_OFF: begin
              is_on_d = 1'b0; is_bend_d = 1'b0;
              if (off_any) begin
                voice_d = off_sel;
                vol_d = 4'd0;
                vnote_d[off_sel] = mva_pkg::FREE_MARK;
              end
            end
            default: begin
              is_on_d = 1'b0; is_bend_d = 1'b1;
              cbend_d[cmd_i.ch] = new_bend;
              bend_d = new_bend;
              mask_d = bmask;
            end
          endcase
        end
      end
      mva_pkg::B_VOL: begin
        if (emit_ok && room) begin
          ov_d = 1'b1;
          cs_d = vdiv[0];
          addr_d = mva_pkg::REG_VOL_BASE + vmod;
          data_d = {4'd0, vol_q};
          last_d = !is_on_q || at_last;
          wcnt_d = wcnt_q + WW'(1);
        end
      end
      mva_pkg::B_PSTART: per_req_o.start = 1'b1;
      mva_pkg::B_PWAIT:  if (per_rsp_i.done) per_d = per_rsp_i.period;
      mva_pkg::B_LO: begin
        if (emit_ok && room) begin
          ov_d = 1'b1;
          cs_d = vdiv[0];
          addr_d = {vmod[2:0], 1'b0};
          data_d = per_q[7:0];
          last_d = at_last;
          wcnt_d = wcnt_q + WW'(1);
        end
      end
      mva_pkg::B_HI: begin
        if (emit_ok && room) begin
          ov_d = 1'b1;
          cs_d = vdiv[0];
          addr_d = {vmod[2:0], 1'b1};
          data_d = per_q[15:8];
          last_d = final_q || at_last;
          wcnt_d = wcnt_q + WW'(1);
        end
      end
      mva_pkg::B_SCAN: begin
        if (mask_q != '0) begin
          voice_d = scan_idx;
          note_d = vnote_q[scan_idx][6:0];
          mask_d = mask_rest;
          final_d = (mask_rest == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mva_pkg::B_IDLE;
      mode_q <= 1'b0;
      ov_q <= 1'b0;
      pc_q <= 8'd0;
      for (int i = 0; i < VC; i++) begin
        vnote_q[i] <= mva_pkg::FREE_MARK;
        vch_q[i] <= 4'd0;
        vorder_q[i] <= 8'd0;
      end
      for (int i = 0; i < mva_pkg::MIDI_CHANNELS; i++) begin
        cbend_q[i] <= 14'd0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) mode_q <= cfg_i.alloc_mode;
      ov_q <= ov_d;
      pc_q <= pc_d;
      vnote_q <= vnote_d;
      vch_q <= vch_d;
      vorder_q <= vorder_d;
      cbend_q <= cbend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    voice_q <= voice_d; note_q <= note_d; bend_q <= bend_d; vol_q <= vol_d;
    is_on_q <= is_on_d; is_bend_q <= is_bend_d; final_q <= final_d;
    mask_q <= mask_d; wcnt_q <= wcnt_d; per_q <= per_d;
    cs_q <= cs_d; addr_q <= addr_d; data_q <= data_d; last_q <= last_d;
  end

endmodule

>>> src/midi_voice_allocator_ay_writer_unit.sv
// Top level of the MIDI voice allocator: front end, command queue, back end and
// tone period unit. Depends on mva_pkg, the channel interfaces and all submodules.
// A note on holds the back end through pop, volume write, period request, the tone
// period unit (7 multiply steps and a done state) and two period writes.
// A pitch bend rewrites the period of each busy voice of its channel; a note off pops and writes the volume.
// Output stalls lengthen each sequence. Reset frees all voices and clears orders, counter and bends.
module midi_voice_allocator_ay_writer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  mva_in_if.sink     in_i,
  mva_cfg_if.sink    cfg_i,
  mva_out_if.source  out_o
);

  logic              cmd_valid, cmd_pop;
  mva_pkg::cmd_t     cmd;
  mva_pkg::per_req_t per_req;
  mva_pkg::per_rsp_t per_rsp;

  mva_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mva_period u_period (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (per_req),
    .rsp_o  (per_rsp)
  );

  mva_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .out_o       (out_o),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .per_req_o   (per_req),
    .per_rsp_i   (per_rsp)
  );

endmodule

>>> sim/tb_midi_voice_allocator_ay_writer_unit.sv
// Self-checking testbench of the MIDI voice allocator: directed and random MIDI events,
// predicted register writes compared item by item. Depends on mva_pkg, the channel
// interfaces and the top level midi_voice_allocator_ay_writer_unit.
module tb_midi_voice_allocator_ay_writer_unit;

  typedef struct packed {
    logic       chip_select;
    logic [3:0] reg_address;
    logic [7:0] reg_data;
    logic       last;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  mva_in_if in_ch();
  mva_cfg_if cfg_ch();
  mva_out_if out_ch();

  midi_voice_allocator_ay_writer_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .cfg_i(cfg_ch), .out_o(out_ch)
  );

  localparam logic [63:0] SEMI_TAB [12] = '{131072, 138866, 147123, 155872, 165140, 174960,
    185364, 196386, 208064, 220436, 233544, 247431};
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  reg_write_t write_queue[$];
  int failures = 0;
  int writes_seen = 0;
  int events_sent = 0;
  int cycles = 0;
  logic stall_long = 1'b0;

  logic        mode_q;
  logic [7:0]  v_note [mva_pkg::VOICE_COUNT];
  logic [3:0]  v_chan [mva_pkg::VOICE_COUNT];
  logic [7:0]  v_order [mva_pkg::VOICE_COUNT];
  logic [7:0]  play_cnt;
  logic [13:0] ch_bend [mva_pkg::MIDI_CHANNELS];

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] calc_period(logic [6:0] nt, logic [13:0] b14);
    int signed bo, p;
    int unsigned q, e, r, s, f, shr;
    logic [63:0] t, t2, t3, fine, m, total;
    bo = int'(b14);
    if (b14[13]) bo = bo - 16384;
    p = (int'(nt) - 69) * 4096 + bo;
    q = 294912 - p;
    e = q / 49152; r = q % 49152; s = r / 4096; f = r % 4096;
    t = 64'(f) * 15142;
    t2 = (t * t) >> 30;
    t3 = (t2 * t) >> 30;
    fine = (64'd1 << 30) + t + t2 / 2 + t3 / 6;
    m = (SEMI_TAB[s % 12] * fine) >> 17;
    total = 64'd111861 * m;
    shr = (e <= 36) ? 36 - e : 0;
    if (shr > 40) shr = 40;
    return 16'(total / (64'd440 << shr));
  endfunction

  function automatic void push_write(inout int n, input int v, input logic [3:0] a,
                                     input logic [7:0] d);
    reg_write_t w;
    if (n >= mva_pkg::MAX_RESULTS) return;
    w.chip_select = 1'((v / 3) & 1);
    w.reg_address = a;
    w.reg_data = d;
    w.last = 1'b0;
    write_queue.push_back(w);
    n++;
  endfunction

  function automatic void push_period(inout int n, input int v, input logic [6:0] nt,
                                      input logic [3:0] ch);
    logic [15:0] per;
    per = calc_period(nt, ch_bend[ch]);
    push_write(n, v, 4'((v % 3) * 2), per[7:0]);
    push_write(n, v, 4'((v % 3) * 2 + 1), per[15:8]);
  endfunction

  function automatic int pick_voice();
    logic [7:0] j;
    for (int i = 0; i < mva_pkg::VOICE_COUNT; i++) if (v_note[i][7]) return i;
    for (j = play_cnt + 8'd1; j != play_cnt; j++)
      for (int i = 0; i < mva_pkg::VOICE_COUNT; i++) if (v_order[i] == j) return i;
    return -1;
  endfunction

  function automatic void predict_writes(logic [1:0] act, logic [3:0] ch, logic [6:0] nt,
                                         logic [6:0] vel, logic [13:0] bend);
    int n, v;
    n = 0; v = -1;
    if (act == mva_pkg::ACT_NOTE_ON && vel == 0) act = mva_pkg::ACT_NOTE_OFF;
    if (act == mva_pkg::ACT_NOTE_ON) begin
      if (!mode_q) v = pick_voice();
      else if (ch < mva_pkg::VOICE_COUNT) v = ch;
      if (v >= 0) begin
        push_write(n, v, 4'(mva_pkg::REG_VOL_BASE + v % 3), 8'(vel >> 3));
        push_period(n, v, nt, ch);
        v_note[v] = {1'b0, nt};
        v_chan[v] = ch;
        v_order[v] = play_cnt;
        play_cnt++;
      end
    end else if (act == mva_pkg::ACT_NOTE_OFF) begin
      if (!mode_q) begin
        for (int i = 0; i < mva_pkg::VOICE_COUNT; i++)
          if (v_note[i] == {1'b0, nt}) begin v = i; break; end
      end else if (ch < mva_pkg::VOICE_COUNT) begin
        v = ch;
      end
      if (v >= 0) begin
        push_write(n, v, 4'(mva_pkg::REG_VOL_BASE + v % 3), 8'd0);
        v_note[v] = mva_pkg::FREE_MARK;
      end
    end else if (act == mva_pkg::ACT_BEND) begin
      ch_bend[ch] = bend - mva_pkg::BEND_CENTER;
      for (int i = 0; i < mva_pkg::VOICE_COUNT; i++)
        if (v_chan[i] == ch && !v_note[i][7]) push_period(n, i, v_note[i][6:0], ch);
    end
    if (n > 0) write_queue[$].last = 1'b1;
  endfunction

  // The item stays on the bus after acceptance until the next item or an idle period.
  task automatic send_event(logic [1:0] act, logic [3:0] ch, logic [6:0] nt,
                            logic [6:0] vel, logic [13:0] bend);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.midi_channel <= ch;
    in_ch.note <= nt;
    in_ch.velocity <= vel;
    in_ch.bend_value <= bend;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_writes(act, ch, nt, vel, bend);
    events_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (write_queue.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic set_mode(logic mode);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.alloc_mode <= mode;
    do @(posedge clk_i); while (!cfg_ch.ready);
    mode_q = mode;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_event(logic [1:0] act);
    send_event(act, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127)), 14'($urandom_range(0, 16383)));
  endtask

  task automatic test_ring_directed();
    send_event(mva_pkg::ACT_NOTE_ON, 4'd0, 7'd0, 7'd127, 14'd0);
    send_event(mva_pkg::ACT_NOTE_ON, 4'd15, 7'd127, 7'd1, 14'd0);
    send_event(mva_pkg::ACT_NOTE_ON, 4'd1, 7'd69, 7'd64, 14'd0);
    send_event(mva_pkg::ACT_BEND, 4'd1, 7'd0, 7'd0, 14'd0);
    send_event(mva_pkg::ACT_BEND, 4'd1, 7'd0, 7'd0, 14'd16383);
    send_event(mva_pkg::ACT_BEND, 4'd15, 7'd0, 7'd0, 14'd8192);
    send_event(mva_pkg::ACT_BEND, 4'd9, 7'd0, 7'd0, 14'd100);
    for (int i = 0; i < 5; i++)
      send_event(mva_pkg::ACT_NOTE_ON, 4'd2, 7'(60 + i), 7'd90, 14'd0);
    send_event(mva_pkg::ACT_NOTE_ON, 4'd2, 7'd40, 7'd0, 14'd0);
    send_event(mva_pkg::ACT_NOTE_OFF, 4'd5, 7'd127, 7'd0, 14'd0);
    send_event(mva_pkg::ACT_NOTE_OFF, 4'd5, 7'd127, 7'd0, 14'd0);
    send_event(ACT_NONE, 4'd3, 7'd64, 7'd64, 14'd3);
    send_event(mva_pkg::ACT_BEND, 4'd2, 7'd0, 7'd0, 14'd12288);
  endtask

  task automatic test_channel_directed();
    send_event(mva_pkg::ACT_NOTE_ON, 4'd5, 7'd20, 7'd127, 14'd0);
    send_event(mva_pkg::ACT_NOTE_ON, 4'd6, 7'd20, 7'd127, 14'd0);
    send_event(mva_pkg::ACT_NOTE_OFF, 4'd3, 7'd1, 7'd0, 14'd0);
    send_event(mva_pkg::ACT_NOTE_OFF, 4'd5, 7'd99, 7'd0, 14'd0);
  endtask

  task automatic test_random(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) random_event(mva_pkg::ACT_NOTE_ON);
      else if (r < 75) random_event(mva_pkg::ACT_NOTE_OFF);
      else if (r < 97) random_event(mva_pkg::ACT_BEND);
      else random_event(ACT_NONE);
    end
  endtask

  task automatic test_ring_held_notes(int count);
    logic [6:0] held [$];
    int idx;
    for (int k = 0; k < count; k++) begin
      if (held.size() > 4 && $urandom_range(0, 1)) begin
        idx = $urandom_range(0, held.size() - 1);
        send_event(mva_pkg::ACT_NOTE_OFF, 4'($urandom_range(0, 15)), held[idx], 7'd0,
                   14'd0);
        held.delete(idx);
      end else if ($urandom_range(0, 4) == 0) begin
        random_event(mva_pkg::ACT_BEND);
      end else begin
        held.push_back(7'($urandom_range(0, 127)));
        send_event(mva_pkg::ACT_NOTE_ON, 4'($urandom_range(0, 3)), held[$],
                   7'($urandom_range(1, 127)), 14'd0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    reg_write_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.chip_select, out_ch.reg_address, out_ch.reg_data, out_ch.last};
      writes_seen <= writes_seen + 1;
      if (write_queue.size() == 0) begin
        $error("unexpected write: chip %0d reg %0d data %0d", got.chip_select,
               got.reg_address, got.reg_data);
        failures++;
      end else begin
        want = write_queue.pop_front();
        if (got.chip_select !== want.chip_select) begin
          $error("chip_select: expected %0d, got %0d", want.chip_select, got.chip_select);
          failures++;
        end
        if (got.reg_address !== want.reg_address) begin
          $error("reg_address: expected %0d, got %0d", want.reg_address, got.reg_address);
          failures++;
        end
        if (got.reg_data !== want.reg_data) begin
          $error("reg_data: expected %0d, got %0d", want.reg_data, got.reg_data);
          failures++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          failures++;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL midi_voice_allocator_ay_writer_unit");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (stall_long) begin
      out_ch.ready <= 1'b0;
      if ($urandom_range(0, 30) == 0) stall_long <= 1'b0;
    end else if ($urandom_range(0, 99) < 3) begin
      stall_long <= 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = mva_pkg::ACT_NOTE_ON;
    in_ch.midi_channel = '0;
    in_ch.note = '0;
    in_ch.velocity = '0;
    in_ch.bend_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.alloc_mode = 1'b0;
    out_ch.ready = 1'b0;
    mode_q = 1'b0;
    play_cnt = '0;
    for (int i = 0; i < mva_pkg::VOICE_COUNT; i++) begin
      v_note[i] = mva_pkg::FREE_MARK;
      v_chan[i] = '0;
      v_order[i] = '0;
    end
    for (int i = 0; i < mva_pkg::MIDI_CHANNELS; i++) ch_bend[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_ring_directed();
    set_mode(1'b1);
    test_channel_directed();
    test_random(60);
    set_mode(1'b0);
    test_ring_held_notes(200);
    test_random(80);
    set_mode(1'b1);
    test_random(40);
    set_mode(1'b0);
    test_random(20);
    wait_idle();
    $display("Covered %0d MIDI events and %0d register writes in ring and channel modes,",
             events_sent, writes_seen);
    $display("including voice stealing, zero velocity, bends and ignored actions.");
    if (failures == 0) $display("PASS midi_voice_allocator_ay_writer_unit");
    else $display("FAIL midi_voice_allocator_ay_writer_unit");
    $finish;
  end
endmodule

>>> files.f
src/mva_pkg.sv
src/mva_in_if.sv
src/mva_out_if.sv
src/mva_cfg_if.sv
src/mva_front.sv
src/mva_period.sv
src/mva_back.sv
src/midi_voice_allocator_ay_writer_unit.sv
sim/tb_midi_voice_allocator_ay_writer_unit.sv
